/* rtl/core/fsss_pkg.sv */
// fsss_pkg: types, codes and constants of the FIX session sequence supervisor.
// Used by the channel interfaces, the step logic and the top level.
package fsss_pkg;

  localparam int SEQ_W  = 31;
  localparam int TIME_W = 32;
  localparam int ID_W   = 32;
  localparam int REG_W  = 16;

  localparam logic [REG_W-1:0] HB_INTERVAL_RST = 16'd5;
  localparam logic [REG_W-1:0] HB_LATENCY_RST  = 16'd1;
  localparam logic [ID_W-1:0]  TEST_ID_RST     = 32'd1;

  typedef enum logic [0:0] {
    CFG_HB_INTERVAL = 1'b0,
    CFG_HB_LATENCY  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    RT_INBOUND   = 3'd0,
    RT_SEQ_RESET = 3'd1,
    RT_HEARTBEAT = 3'd2,
    RT_TICK      = 3'd3,
    RT_OUTBOUND  = 3'd4,
    RT_END_OF_DAY = 3'd5,
    RT_RESTORE   = 3'd6
  } req_type_t;

  typedef enum logic [3:0] {
    V_OK           = 4'd0,
    V_GAP_IGNORE   = 4'd1,
    V_LOW_CLOSE    = 4'd2,
    V_RESET        = 4'd3,
    V_BAD_NEW      = 4'd4,
    V_AHEAD_CLOSE  = 4'd5,
    V_HB_NO_ID     = 4'd6,
    V_HB_MATCH     = 4'd7,
    V_HB_MISMATCH  = 4'd8,
    V_IDLE         = 4'd9,
    V_TEST_SENT    = 4'd10,
    V_TIMEOUT      = 4'd11,
    V_OUT_ASSIGNED = 4'd12,
    V_SEQ_SET      = 4'd13
  } verdict_t;

  typedef enum logic [1:0] {
    SK_NONE   = 2'd0,
    SK_RESEND = 2'd1,
    SK_TEST   = 2'd2
  } send_kind_t;

  typedef struct packed {
    req_type_t         req_type;
    logic [TIME_W-1:0] now_seconds;
    logic [SEQ_W-1:0]  msg_seq;
    logic [SEQ_W-1:0]  new_seq;
    logic              fill_mode;
    logic              has_req_id;
    logic [ID_W-1:0]   req_id;
    logic [SEQ_W-1:0]  restore_in_seq;
    logic [SEQ_W-1:0]  restore_out_seq;
  } req_t;

  typedef struct packed {
    verdict_t          verdict;
    send_kind_t        send_kind;
    logic [SEQ_W-1:0]  send_seq;
    logic [SEQ_W-1:0]  resend_begin;
    logic [ID_W-1:0]   test_req_id;
    logic [SEQ_W-1:0]  expected_last;
    logic [SEQ_W-1:0]  gap_target;
  } rsp_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  in_seq_last;
    logic [SEQ_W-1:0]  out_seq_last;
    logic [SEQ_W-1:0]  gap_high;
    logic [ID_W-1:0]   test_id_counter;
    logic [TIME_W-1:0] test_sent_time;
    logic [TIME_W-1:0] last_recv_time;
  } sess_t;

  typedef struct packed {
    logic [REG_W-1:0] hb_interval;
    logic [REG_W-1:0] hb_latency;
  } cfg_t;

endpackage

/* rtl/core/fsss_chan_if.sv */
// fsss_chan_if: valid/ready channels for request beats and result beats.
// Depends on fsss_pkg for field widths.
interface fsss_in_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   req_type;
  logic [fsss_pkg::TIME_W-1:0]  now_seconds;
  logic [fsss_pkg::SEQ_W-1:0]   msg_seq;
  logic [fsss_pkg::SEQ_W-1:0]   new_seq;
  logic                         fill_mode;
  logic                         has_req_id;
  logic [fsss_pkg::ID_W-1:0]    req_id;
  logic [fsss_pkg::SEQ_W-1:0]   restore_in_seq;
  logic [fsss_pkg::SEQ_W-1:0]   restore_out_seq;

  modport source (output valid, req_type, now_seconds, msg_seq, new_seq, fill_mode,
                  has_req_id, req_id, restore_in_seq, restore_out_seq, input ready);
  modport sink (input valid, req_type, now_seconds, msg_seq, new_seq, fill_mode,
                has_req_id, req_id, restore_in_seq, restore_out_seq, output ready);
endinterface

interface fsss_out_if;
  logic                         valid;
  logic                         ready;
  logic [3:0]                   verdict;
  logic [1:0]                   send_kind;
  logic [fsss_pkg::SEQ_W-1:0]   send_seq;
  logic [fsss_pkg::SEQ_W-1:0]   resend_begin;
  logic [fsss_pkg::ID_W-1:0]    test_req_id;
  logic [fsss_pkg::SEQ_W-1:0]   expected_last;
  logic [fsss_pkg::SEQ_W-1:0]   gap_target;

  modport source (output valid, verdict, send_kind, send_seq, resend_begin, test_req_id,
                  expected_last, gap_target, input ready);
  modport sink (input valid, verdict, send_kind, send_seq, resend_begin, test_req_id,
                expected_last, gap_target, output ready);
endinterface

/* rtl/core/fsss_step.sv */
// fsss_step: next session state and result beat for one request.
// Depends on fsss_pkg.
module fsss_step (
  input  fsss_pkg::req_t  req,
  input  fsss_pkg::sess_t cur,
  input  fsss_pkg::cfg_t  cfg,
  output fsss_pkg::sess_t nxt,
  output fsss_pkg::rsp_t  rsp
);

  logic [fsss_pkg::SEQ_W:0]      expect_seq;
  logic [fsss_pkg::REG_W-1:0]    hbt;
  logic [fsss_pkg::REG_W-1:0]    lat;
  logic [fsss_pkg::TIME_W:0]     idle_lim;
  logic [fsss_pkg::TIME_W+1:0]   tmo_lim;
  logic [fsss_pkg::SEQ_W-1:0]    out_inc;
  logic [fsss_pkg::SEQ_W-1:0]    new_dec;
  logic [fsss_pkg::ID_W-1:0]     id_inc;

  assign expect_seq = {1'b0, cur.in_seq_last} + (fsss_pkg::SEQ_W+1)'(1);
  assign hbt = (cfg.hb_interval == '0) ? fsss_pkg::HB_INTERVAL_RST : cfg.hb_interval;
  assign lat = (cfg.hb_latency == '0) ? fsss_pkg::HB_LATENCY_RST : cfg.hb_latency;
  assign idle_lim = {1'b0, cur.last_recv_time} + (fsss_pkg::TIME_W+1)'(hbt);
  assign tmo_lim = {2'b0, cur.test_sent_time} + (fsss_pkg::TIME_W+2)'(hbt)
                 + (fsss_pkg::TIME_W+2)'(lat);
  assign out_inc = cur.out_seq_last + fsss_pkg::SEQ_W'(1);
  assign new_dec = req.new_seq - fsss_pkg::SEQ_W'(1);
  assign id_inc = cur.test_id_counter + fsss_pkg::ID_W'(1);

  always_comb begin
    nxt              = cur;
    rsp.verdict      = fsss_pkg::V_IDLE;
    rsp.send_kind    = fsss_pkg::SK_NONE;
    rsp.send_seq     = '0;
    rsp.resend_begin = '0;
    rsp.test_req_id  = '0;

    unique case (req.req_type)
      fsss_pkg::RT_INBOUND: begin
        nxt.last_recv_time = req.now_seconds;
        if (req.msg_seq <= cur.in_seq_last) begin
          nxt.gap_high = '0;
          rsp.verdict  = fsss_pkg::V_LOW_CLOSE;
        end else if ({1'b0, req.msg_seq} == expect_seq) begin
          nxt.gap_high    = '0;
          nxt.in_seq_last = req.msg_seq;
          rsp.verdict     = fsss_pkg::V_OK;
        end else begin
          if (req.msg_seq > cur.gap_high) begin
            if (cur.gap_high == '0) begin
              nxt.test_sent_time = '0;
              nxt.out_seq_last   = out_inc;
              rsp.send_kind      = fsss_pkg::SK_RESEND;
              rsp.resend_begin   = expect_seq[fsss_pkg::SEQ_W-1:0];
              rsp.send_seq       = out_inc;
            end
            nxt.gap_high = req.msg_seq;
          end
          rsp.verdict = fsss_pkg::V_GAP_IGNORE;
        end
      end
      fsss_pkg::RT_SEQ_RESET: begin
        nxt.last_recv_time = req.now_seconds;
        if (req.new_seq == '0) begin
          nxt.gap_high = '0;
          rsp.verdict  = fsss_pkg::V_BAD_NEW;
        end else if (!req.fill_mode) begin
          nxt.in_seq_last = new_dec;
          rsp.verdict     = fsss_pkg::V_RESET;
        end else if (req.msg_seq <= cur.in_seq_last) begin
          nxt.gap_high = '0;
          rsp.verdict  = fsss_pkg::V_LOW_CLOSE;
        end else if ({1'b0, req.msg_seq} > expect_seq) begin
          nxt.gap_high = '0;
          rsp.verdict  = fsss_pkg::V_AHEAD_CLOSE;
        end else begin
          if (req.new_seq >= cur.gap_high) begin
            nxt.gap_high = '0;
          end
          nxt.in_seq_last = new_dec;
          rsp.verdict     = fsss_pkg::V_RESET;
        end
      end
      fsss_pkg::RT_HEARTBEAT: begin
        nxt.last_recv_time = req.now_seconds;
        if (!req.has_req_id) begin
          rsp.verdict = fsss_pkg::V_HB_NO_ID;
        end else if (req.req_id == cur.test_id_counter) begin
          nxt.test_sent_time = '0;
          rsp.verdict        = fsss_pkg::V_HB_MATCH;
        end else begin
          rsp.verdict = fsss_pkg::V_HB_MISMATCH;
        end
      end
      fsss_pkg::RT_TICK: begin
        if ({1'b0, req.now_seconds} > idle_lim) begin
          if (cur.test_sent_time != '0) begin
            if ({2'b0, req.now_seconds} > tmo_lim) begin
              nxt.gap_high = '0;
              rsp.verdict  = fsss_pkg::V_TIMEOUT;
            end
          end else begin
            nxt.out_seq_last    = out_inc;
            nxt.test_id_counter = id_inc;
            nxt.test_sent_time  = req.now_seconds;
            rsp.send_seq        = out_inc;
            rsp.test_req_id     = id_inc;
            rsp.send_kind       = fsss_pkg::SK_TEST;
            rsp.verdict         = fsss_pkg::V_TEST_SENT;
          end
        end
      end
      fsss_pkg::RT_OUTBOUND: begin
        nxt.out_seq_last = out_inc;
        rsp.send_seq     = out_inc;
        rsp.verdict      = fsss_pkg::V_OUT_ASSIGNED;
      end
      fsss_pkg::RT_END_OF_DAY: begin
        nxt.in_seq_last  = '0;
        nxt.out_seq_last = '0;
        rsp.verdict      = fsss_pkg::V_SEQ_SET;
      end
      fsss_pkg::RT_RESTORE: begin
        nxt.in_seq_last  = req.restore_in_seq;
        nxt.out_seq_last = req.restore_out_seq;
        rsp.verdict      = fsss_pkg::V_SEQ_SET;
      end
      default: begin
        rsp.verdict = fsss_pkg::V_IDLE;
      end
    endcase

    rsp.expected_last = nxt.in_seq_last;
    rsp.gap_target    = nxt.gap_high;
  end

endmodule

/* rtl/core/fix_session_sequence_supervisor.sv */
// Sequence and liveness supervisor of a FIX-style session: top level.
// Depends on fsss_pkg, fsss_chan_if and fsss_step.
// One request beat is taken every cycle while the result path is not stalled, and each gives
// exactly one result beat. A beat lands in the request register; the session state and the
// result register are updated from it once the result register is free, and the result is
// then shown. As fsss_step computes the next session state combinationally, the rate is one
// beat per cycle unless the output stalls. Write the heartbeat registers only while no beat
// is in flight.
module fix_session_sequence_supervisor (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [fsss_pkg::REG_W-1:0] cfg_wdata,
  fsss_in_if.sink                   in_if,
  fsss_out_if.source                out_if
);

  fsss_pkg::req_t  req_r;
  logic            req_vld_r;
  fsss_pkg::sess_t sess_r;
  fsss_pkg::sess_t sess_nxt;
  fsss_pkg::cfg_t  cfg_r;
  fsss_pkg::rsp_t  rsp_r;
  fsss_pkg::rsp_t  rsp_nxt;
  logic            rsp_vld_r;
  logic            rsp_free;
  logic            req_adv;
  logic            in_take;

  assign rsp_free = !rsp_vld_r || out_if.ready;
  assign req_adv  = req_vld_r && rsp_free;
  assign in_if.ready = !req_vld_r || rsp_free;
  assign in_take  = in_if.valid && in_if.ready;

  fsss_step u_step (
    .req (req_r),
    .cur (sess_r),
    .cfg (cfg_r),
    .nxt (sess_nxt),
    .rsp (rsp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hb_interval <= fsss_pkg::HB_INTERVAL_RST;
      cfg_r.hb_latency  <= fsss_pkg::HB_LATENCY_RST;
    end else if (cfg_we) begin
      unique case (fsss_pkg::cfg_idx_t'(cfg_index))
        fsss_pkg::CFG_HB_INTERVAL: cfg_r.hb_interval <= cfg_wdata;
        fsss_pkg::CFG_HB_LATENCY:  cfg_r.hb_latency  <= cfg_wdata;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      req_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.req_type        <= fsss_pkg::req_type_t'(in_if.req_type);
      req_r.now_seconds     <= in_if.now_seconds;
      req_r.msg_seq         <= in_if.msg_seq;
      req_r.new_seq         <= in_if.new_seq;
      req_r.fill_mode       <= in_if.fill_mode;
      req_r.has_req_id      <= in_if.has_req_id;
      req_r.req_id          <= in_if.req_id;
      req_r.restore_in_seq  <= in_if.restore_in_seq;
      req_r.restore_out_seq <= in_if.restore_out_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sess_r.in_seq_last     <= '0;
      sess_r.out_seq_last    <= '0;
      sess_r.gap_high        <= '0;
      sess_r.test_id_counter <= fsss_pkg::TEST_ID_RST;
      sess_r.test_sent_time  <= '0;
      sess_r.last_recv_time  <= '0;
    end else if (req_adv) begin
      sess_r <= sess_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_vld_r <= 1'b0;
    end else if (rsp_free) begin
      rsp_vld_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_adv) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_if.valid         = rsp_vld_r;
  assign out_if.verdict       = rsp_r.verdict;
  assign out_if.send_kind     = rsp_r.send_kind;
  assign out_if.send_seq      = rsp_r.send_seq;
  assign out_if.resend_begin  = rsp_r.resend_begin;
  assign out_if.test_req_id   = rsp_r.test_req_id;
  assign out_if.expected_last = rsp_r.expected_last;
  assign out_if.gap_target    = rsp_r.gap_target;

  a_rsp_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    req_adv |=> (rsp_r.expected_last == sess_r.in_seq_last &&
                 rsp_r.gap_target == sess_r.gap_high))
    else $error("result beat disagrees with session state");

  a_resend_on_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_vld_r && rsp_r.send_kind == fsss_pkg::SK_RESEND) |->
      (rsp_r.verdict == fsss_pkg::V_GAP_IGNORE && rsp_r.send_seq == sess_r.out_seq_last
       || !$stable(sess_r)))
    else $error("resend request without a gap");

  a_test_numbered: assert property (@(posedge clk) disable iff (!rst_n)
    (req_adv && rsp_nxt.send_kind == fsss_pkg::SK_TEST) |=>
      (sess_r.test_id_counter == rsp_r.test_req_id &&
       sess_r.test_sent_time == $past(req_r.now_seconds)))
    else $error("test request id or send time not held");

  a_silent_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_vld_r && rsp_r.send_kind == fsss_pkg::SK_NONE) |->
      (rsp_r.resend_begin == '0 && rsp_r.test_req_id == '0))
    else $error("request fields set on a beat that emits nothing");

endmodule

/* verif/fix_session_sequence_supervisor_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for fix_session_sequence_supervisor: session request beats in,
// one result beat out each, checked against an in-bench session tracker.
// Depends on fsss_pkg, fsss_chan_if and the top level of the block.
module fix_session_sequence_supervisor_tb;
  import fsss_pkg::*;

  localparam logic [2:0] RT_UNUSED = 3'd7;

  class seq_tracker;
    logic [REG_W-1:0]  hb_interval;
    logic [REG_W-1:0]  hb_latency;
    logic [SEQ_W-1:0]  in_last;
    logic [SEQ_W-1:0]  out_last;
    logic [SEQ_W-1:0]  gap_high;
    logic [ID_W-1:0]   test_id;
    logic [TIME_W-1:0] test_sent;
    logic [TIME_W-1:0] last_rx;
    rsp_t              due_rsp[$];
    int unsigned       errs;

    function new();
      hb_interval = HB_INTERVAL_RST;
      hb_latency  = HB_LATENCY_RST;
      in_last     = '0;
      out_last    = '0;
      gap_high    = '0;
      test_id     = TEST_ID_RST;
      test_sent   = '0;
      last_rx     = '0;
      errs        = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [REG_W-1:0] v);
      if (idx == CFG_HB_INTERVAL) hb_interval = v;
      else hb_latency = v;
    endfunction

    function int pending();
      return due_rsp.size();
    endfunction

    function logic [SEQ_W-1:0] bump_out();
      out_last = out_last + 1'b1;
      return out_last;
    endfunction

    function void take_request(req_t r);
      rsp_t            e;
      logic [31:0]     nxt;
      longint unsigned hb;
      longint unsigned lt;
      longint unsigned now;
      e = '0;
      e.verdict = V_IDLE;
      e.send_kind = SK_NONE;
      nxt = {1'b0, in_last} + 32'd1;
      hb = (hb_interval == '0) ? 5 : hb_interval;
      lt = (hb_latency == '0) ? 1 : hb_latency;
      now = r.now_seconds;
      if (r.req_type <= RT_HEARTBEAT) last_rx = r.now_seconds;
      case (r.req_type)
        RT_INBOUND: begin
          if (r.msg_seq <= in_last) begin
            gap_high = '0;
            e.verdict = V_LOW_CLOSE;
          end else if ({1'b0, r.msg_seq} == nxt) begin
            gap_high = '0;
            in_last = r.msg_seq;
            e.verdict = V_OK;
          end else begin
            if (r.msg_seq > gap_high) begin
              if (gap_high == '0) begin
                test_sent = '0;
                e.send_kind = SK_RESEND;
                e.resend_begin = nxt[SEQ_W-1:0];
                e.send_seq = bump_out();
              end
              gap_high = r.msg_seq;
            end
            e.verdict = V_GAP_IGNORE;
          end
        end
        RT_SEQ_RESET: begin
          if (r.new_seq == '0) begin
            gap_high = '0;
            e.verdict = V_BAD_NEW;
          end else if (!r.fill_mode) begin
            in_last = r.new_seq - 1'b1;
            e.verdict = V_RESET;
          end else if (r.msg_seq <= in_last) begin
            gap_high = '0;
            e.verdict = V_LOW_CLOSE;
          end else if ({1'b0, r.msg_seq} > nxt) begin
            gap_high = '0;
            e.verdict = V_AHEAD_CLOSE;
          end else begin
            if (r.new_seq >= gap_high) gap_high = '0;
            in_last = r.new_seq - 1'b1;
            e.verdict = V_RESET;
          end
        end
        RT_HEARTBEAT: begin
          if (!r.has_req_id) begin
            e.verdict = V_HB_NO_ID;
          end else if (r.req_id == test_id) begin
            test_sent = '0;
            e.verdict = V_HB_MATCH;
          end else begin
            e.verdict = V_HB_MISMATCH;
          end
        end
        RT_TICK: begin
          if (now > longint'(last_rx) + hb) begin
            if (test_sent != '0) begin
              if (now > longint'(test_sent) + hb + lt) begin
                gap_high = '0;
                e.verdict = V_TIMEOUT;
              end
            end else begin
              e.send_seq = bump_out();
              test_id = test_id + 1'b1;
              e.test_req_id = test_id;
              test_sent = r.now_seconds;
              e.send_kind = SK_TEST;
              e.verdict = V_TEST_SENT;
            end
          end
        end
        RT_OUTBOUND: begin
          e.send_seq = bump_out();
          e.verdict = V_OUT_ASSIGNED;
        end
        RT_END_OF_DAY: begin
          in_last = '0;
          out_last = '0;
          e.verdict = V_SEQ_SET;
        end
        RT_RESTORE: begin
          in_last = r.restore_in_seq;
          out_last = r.restore_out_seq;
          e.verdict = V_SEQ_SET;
        end
        default: ;
      endcase
      e.expected_last = in_last;
      e.gap_target = gap_high;
      due_rsp.push_back(e);
    endfunction

    function void match_result(rsp_t got);
      rsp_t e;
      if (due_rsp.size() == 0) begin
        $error("result beat with nothing outstanding: verdict %0d", got.verdict);
        errs++;
        return;
      end
      e = due_rsp.pop_front();
      if (got.verdict !== e.verdict) begin
        $error("verdict: expected %0d, got %0d", e.verdict, got.verdict);
        errs++;
      end
      if (got.send_kind !== e.send_kind) begin
        $error("send_kind: expected %0d, got %0d", e.send_kind, got.send_kind);
        errs++;
      end
      if (got.send_seq !== e.send_seq) begin
        $error("send_seq: expected %0d, got %0d", e.send_seq, got.send_seq);
        errs++;
      end
      if (got.resend_begin !== e.resend_begin) begin
        $error("resend_begin: expected %0d, got %0d", e.resend_begin, got.resend_begin);
        errs++;
      end
      if (got.test_req_id !== e.test_req_id) begin
        $error("test_req_id: expected %0d, got %0d", e.test_req_id, got.test_req_id);
        errs++;
      end
      if (got.expected_last !== e.expected_last) begin
        $error("expected_last: expected %0d, got %0d", e.expected_last, got.expected_last);
        errs++;
      end
      if (got.gap_target !== e.gap_target) begin
        $error("gap_target: expected %0d, got %0d", e.gap_target, got.gap_target);
        errs++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [0:0]        cfg_index;
  logic [REG_W-1:0]  cfg_wdata;
  logic [TIME_W-1:0] now_t = '0;
  bit                in_rush = 1'b0;
  bit                out_rush = 1'b0;
  seq_tracker        sb = new();

  fsss_in_if  in_ch ();
  fsss_out_if out_ch ();

  fix_session_sequence_supervisor DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  always #1 clk = ~clk;

  function automatic req_t mk(req_type_t t, logic [TIME_W-1:0] now,
                              logic [SEQ_W-1:0] mseq = '0, logic [SEQ_W-1:0] nseq = '0,
                              bit gf = 1'b0, bit hid = 1'b0, logic [ID_W-1:0] rid = '0);
    req_t r;
    r.req_type = t;
    r.now_seconds = now;
    r.msg_seq = mseq;
    r.new_seq = nseq;
    r.fill_mode = gf;
    r.has_req_id = hid;
    r.req_id = rid;
    r.restore_in_seq = SEQ_W'($urandom);
    r.restore_out_seq = SEQ_W'($urandom);
    return r;
  endfunction

  function automatic req_t random_req();
    req_t             r;
    int unsigned      pick;
    int unsigned      adv;
    int unsigned      hb;
    int unsigned      lt;
    logic [SEQ_W-1:0] nxt;
    hb = (sb.hb_interval == '0) ? 5 : sb.hb_interval;
    lt = (sb.hb_latency == '0) ? 1 : sb.hb_latency;
    adv = $urandom_range(0, 39);
    if (adv < 6) now_t = now_t + hb + $urandom_range(0, hb + lt + 2);
    else if (adv == 6) now_t = $urandom;
    else if (adv == 7) now_t = 32'hFFFF_FFFF - $urandom_range(0, 2 * (hb + lt));
    else now_t = now_t + $urandom_range(0, 3);
    r = mk(RT_TICK, now_t, SEQ_W'($urandom), SEQ_W'($urandom), 1'($urandom),
           1'($urandom), $urandom);
    nxt = sb.in_last + 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.req_type = RT_INBOUND;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: r.msg_seq = nxt;
        6, 7: r.msg_seq = nxt + SEQ_W'($urandom_range(1, 5));
        8: r.msg_seq = sb.in_last - SEQ_W'($urandom_range(0, 3));
        default: ;
      endcase
    end else if (pick < 50) begin
      r.req_type = RT_SEQ_RESET;
      r.fill_mode = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: r.msg_seq = nxt;
        6: r.msg_seq = nxt + 1'b1;
        7: r.msg_seq = sb.in_last;
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0: r.new_seq = '0;
        1: ;
        2, 3, 4, 5: r.new_seq = sb.gap_high + SEQ_W'($urandom_range(0, 2));
        default: r.new_seq = nxt + SEQ_W'($urandom_range(0, 5));
      endcase
    end else if (pick < 60) begin
      r.req_type = RT_HEARTBEAT;
      r.has_req_id = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) r.req_id = sb.test_id;
    end else if (pick < 78) begin
      r.req_type = RT_TICK;
    end else if (pick < 88) begin
      r.req_type = RT_OUTBOUND;
    end else if (pick < 91) begin
      r.req_type = RT_END_OF_DAY;
    end else if (pick < 95) begin
      r.req_type = RT_RESTORE;
      if ($urandom_range(0, 3) == 0) begin
        r.restore_in_seq = 31'h7FFF_FFFF - SEQ_W'($urandom_range(0, 3));
        r.restore_out_seq = 31'h7FFF_FFFF - SEQ_W'($urandom_range(0, 3));
      end
    end else begin
      r.req_type = req_type_t'($urandom_range(0, 7));
    end
    return r;
  endfunction

  task automatic put_req(input req_t r);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) in_rush = !in_rush;
    gap = in_rush ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid           <= 1'b1;
    in_ch.req_type        <= r.req_type;
    in_ch.now_seconds     <= r.now_seconds;
    in_ch.msg_seq         <= r.msg_seq;
    in_ch.new_seq         <= r.new_seq;
    in_ch.fill_mode       <= r.fill_mode;
    in_ch.has_req_id      <= r.has_req_id;
    in_ch.req_id          <= r.req_id;
    in_ch.restore_in_seq  <= r.restore_in_seq;
    in_ch.restore_out_seq <= r.restore_out_seq;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_request(r);
  endtask

  // hold off until every outstanding result is back, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [REG_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  initial begin
    rsp_t        got;
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 31) == 0) out_rush = !out_rush;
      stall = out_rush ? 0 : $urandom_range(0, 16);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.verdict       = verdict_t'(out_ch.verdict);
      got.send_kind     = send_kind_t'(out_ch.send_kind);
      got.send_seq      = out_ch.send_seq;
      got.resend_begin  = out_ch.resend_begin;
      got.test_req_id   = out_ch.test_req_id;
      got.expected_last = out_ch.expected_last;
      got.gap_target    = out_ch.gap_target;
      sb.match_result(got);
    end
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned      ph;
    logic [REG_W-1:0] iv;
    logic [REG_W-1:0] lv;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.now_seconds = '0;
    in_ch.msg_seq = '0;
    in_ch.new_seq = '0;
    in_ch.fill_mode = 1'b0;
    in_ch.has_req_id = 1'b0;
    in_ch.req_id = '0;
    in_ch.restore_in_seq = '0;
    in_ch.restore_out_seq = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    put_req(mk(RT_INBOUND, 32'd10, 31'd1));
    put_req(mk(RT_INBOUND, 32'd11, 31'd1));
    put_req(mk(RT_INBOUND, 32'd12, 31'd5));
    put_req(mk(RT_INBOUND, 32'd13, 31'd7));
    put_req(mk(RT_INBOUND, 32'd15, 31'd2));
    put_req(mk(RT_SEQ_RESET, 32'd16, 31'd3, 31'd10, 1'b1));
    put_req(mk(RT_SEQ_RESET, 32'd17, 31'd10, 31'd0, 1'b0));
    put_req(mk(RT_SEQ_RESET, 32'd18, 31'd0, 31'd100, 1'b0));
    put_req(mk(RT_SEQ_RESET, 32'd19, 31'd200, 31'd300, 1'b1));
    put_req(mk(RT_SEQ_RESET, 32'd20, 31'd50, 31'd300, 1'b1));
    put_req(mk(RT_HEARTBEAT, 32'd21));
    put_req(mk(RT_HEARTBEAT, 32'd22, '0, '0, 1'b0, 1'b1, 32'hFFFF_FFFF));
    put_req(mk(RT_TICK, 32'd30));
    put_req(mk(RT_HEARTBEAT, 32'd31, '0, '0, 1'b0, 1'b1, 32'd2));
    put_req(mk(RT_TICK, 32'd40));
    put_req(mk(RT_TICK, 32'd45));
    put_req(mk(RT_TICK, 32'd47));
    put_req(mk(RT_OUTBOUND, 32'd48));
    put_req(mk(req_type_t'(RT_UNUSED), 32'd49, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b1));
    put_req(mk(RT_RESTORE, 32'd50, '0, '0, 1'b0, 1'b0, '0));
    put_req(mk(RT_INBOUND, 32'd51, 31'h7FFF_FFFF));
    put_req(mk(RT_OUTBOUND, 32'd52));
    put_req(mk(RT_END_OF_DAY, 32'd53));
    put_req(mk(RT_HEARTBEAT, 32'hFFFF_FFF0));
    put_req(mk(RT_TICK, 32'hFFFF_FFFF));
    put_req(mk(RT_TICK, 32'hFFFF_FFFF));
    settle();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin iv = '0; lv = '0; end
        1: begin iv = 16'd1; lv = 16'd1; end
        2: begin iv = 16'hFFFF; lv = 16'hFFFF; end
        3: begin iv = 16'd3; lv = 16'd2; end
        4: begin
          iv = REG_W'($urandom_range(1, 20));
          lv = REG_W'($urandom_range(1, 20));
        end
        default: begin iv = REG_W'($urandom); lv = REG_W'($urandom); end
      endcase
      write_reg(CFG_HB_INTERVAL, iv);
      write_reg(CFG_HB_LATENCY, lv);
      repeat (80) put_req(random_req());
      settle();
    end

    repeat (8) @(posedge clk);
    if (sb.errs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/core/fsss_pkg.sv
rtl/core/fsss_chan_if.sv
rtl/core/fsss_step.sv
rtl/core/fix_session_sequence_supervisor.sv
verif/fix_session_sequence_supervisor_tb.sv
